/* src/wnd_pkg.sv */
// Shared widths, constants, codes and control types for the windowed diversity block.
package wnd_pkg;

  // Field widths
  localparam int POS_W  = 31;               // position, window index, empty count
  localparam int CNT_W  = 16;               // haplotype and derived counts
  localparam int DIV_W  = 40;               // diversity, Q24.16
  localparam int FRAC_W = 16;
  localparam int INT_W  = DIV_W - FRAC_W;   // integer bits of diversity
  localparam int SUM_W  = 64;               // pair-difference accumulator
  localparam int TERM_W = 2 * CNT_W;        // n1*(H-n1)
  localparam int END_W  = POS_W + 1;        // window end, one bit of headroom
  localparam int STEP_W = 6;                // divider step counter

  // Divider step counts
  localparam logic [STEP_W-1:0] STEPS_TGT = STEP_W'(POS_W);
  localparam logic [STEP_W-1:0] STEPS_PI  = STEP_W'(DIV_W);

  // Configuration
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HAP_COUNT   = 1'd1;
  localparam logic [POS_W-1:0] WINDOW_SIZE_RESET = 31'd1000;
  localparam logic [CNT_W-1:0] HAP_COUNT_RESET   = 16'd2;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_TDIV,
    ST_TCHK,
    ST_PDIV1,
    ST_EMIT1,
    ST_ADD,
    ST_FSTART,
    ST_PDIV2,
    ST_EMIT2
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;    // input transfer, capture the site
    logic div_tgt;  // start (pos-1)/W
    logic div_pi;   // start pair_sum*2^16/pairs
    logic tgt_cap;  // capture target window and its end
    logic win_set;  // target is the open window: refresh window end
    logic close;    // emit the open window, move to the target
    logic add;      // accumulate the site term
    logic fin;      // emit the final window, restart the stream
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fast;     // site stays in the open window, no divide needed
    logic div_done;
    logic tgt_gt;   // target window lies beyond the open window
    logic last;
    logic out_free;
  } stat_t;

endpackage

/* src/wnd_if.sv */
// Valid/ready stream interfaces for sites in and window results out.
interface wnd_site_if import wnd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;
  logic [CNT_W-1:0] derived_count;
  logic             last_site;

  modport source(output valid, position, derived_count, last_site, input ready);
  modport sink(input valid, position, derived_count, last_site, output ready);
endinterface

interface wnd_win_if import wnd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] window_index;
  logic [DIV_W-1:0] diversity;
  logic [POS_W-1:0] empty_after;
  logic             final_window;

  modport source(output valid, window_index, diversity, empty_after, final_window,
                 input ready);
  modport sink(input valid, window_index, diversity, empty_after, final_window,
               output ready);
endinterface

/* src/windowed_nucleotide_diversity_top.sv */
// Top level of the windowed nucleotide diversity block.
//
//   port     dir  transfer when           carries
//   site     in   site.valid & ready      position, derived_count, last_site
//   win      out  win.valid & ready       window_index, diversity, empty_after, final_window
//   cfg_*    in   cfg_we high             register index, write data
//
// A site inside the known open window passes through accept, lookup and accumulate.
// A site with no known window end adds the 31-step window divide; each window
// closed adds the 40-step diversity divide plus emit, and the last site a further
// diversity divide and emit. Rate is set by the shared one-bit-per-cycle divider.
// Reset (rst, synchronous) restores window_size 1000 and hap_count 2 and empties the state.
// A stalled output holds the controller only when a second result is ready to load.
module windowed_nucleotide_diversity_top import wnd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_data,
  wnd_site_if.sink             site,
  wnd_win_if.source            win
);

  cmd_t  cmd;
  stat_t st;

  wnd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (site.valid),
    .in_ready (site.ready),
    .st       (st),
    .cmd      (cmd)
  );

  wnd_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_position      (site.position),
    .in_derived_count (site.derived_count),
    .in_last_site     (site.last_site),
    .cmd              (cmd),
    .st               (st),
    .out_ready        (win.ready),
    .out_valid        (win.valid),
    .out_window_index (win.window_index),
    .out_diversity    (win.diversity),
    .out_empty_after  (win.empty_after),
    .out_final_window (win.final_window)
  );

endmodule

/* src/wnd_div.sv */
// Restoring divider, one quotient bit per cycle, shared by window lookup and diversity.
module wnd_div import wnd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [STEP_W-1:0] steps,
  input  logic [POS_W-1:0]  divisor,
  input  logic [POS_W-1:0]  rem_init,
  input  logic [DIV_W-1:0]  q_init,
  output logic              done,
  output logic [DIV_W-1:0]  quot,
  output logic [POS_W-1:0]  rem
);

  logic              busy;
  logic [STEP_W-1:0] count;
  logic [POS_W-1:0]  dvs;
  logic [POS_W:0]    trial;
  logic              ge;

  // One shift-subtract step
  assign trial = {rem, quot[DIV_W-1]};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= steps;
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      dvs  <= divisor;
      rem  <= rem_init;
      quot <= q_init;
    end else if (busy) begin
      rem  <= ge ? POS_W'(trial - {1'b0, dvs}) : trial[POS_W-1:0];
      quot <= {quot[DIV_W-2:0], ge};
    end
  end

endmodule

/* src/wnd_ctrl.sv */
// Controller: sequences lookup, window close, accumulate and final emit per site.
module wnd_ctrl import wnd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      // Known window end lets most sites skip the divide
      ST_LOOKUP: begin
        if (st.fast) begin
          state_next = ST_ADD;
        end else begin
          cmd.div_tgt = 1'b1;
          state_next  = ST_TDIV;
        end
      end
      ST_TDIV: begin
        if (st.div_done) begin
          cmd.tgt_cap = 1'b1;
          state_next  = ST_TCHK;
        end
      end
      ST_TCHK: begin
        if (st.tgt_gt) begin
          cmd.div_pi = 1'b1;
          state_next = ST_PDIV1;
        end else begin
          cmd.win_set = 1'b1;
          state_next  = ST_ADD;
        end
      end
      ST_PDIV1: begin
        if (st.div_done) begin
          state_next = ST_EMIT1;
        end
      end
      ST_EMIT1: begin
        if (st.out_free) begin
          cmd.close  = 1'b1;
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = st.last ? ST_FSTART : ST_IDLE;
      end
      // Sum now includes the last site
      ST_FSTART: begin
        cmd.div_pi = 1'b1;
        state_next = ST_PDIV2;
      end
      ST_PDIV2: begin
        if (st.div_done) begin
          state_next = ST_EMIT2;
        end
      end
      ST_EMIT2: begin
        if (st.out_free) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* src/wnd_dp.sv */
// Datapath: config registers, window state, pair sum, divider and output register.
module wnd_dp import wnd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_data,
  input  logic [POS_W-1:0]     in_position,
  input  logic [CNT_W-1:0]     in_derived_count,
  input  logic                 in_last_site,
  input  cmd_t                 cmd,
  output stat_t                st,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [POS_W-1:0]     out_window_index,
  output logic [DIV_W-1:0]     out_diversity,
  output logic [POS_W-1:0]     out_empty_after,
  output logic                 out_final_window
);

  // Configuration
  logic [POS_W-1:0] window_size;
  logic [CNT_W-1:0] hap_count;
  logic [POS_W-1:0] wsize;
  logic [POS_W-1:0] pairs;

  // Site and window state
  logic [POS_W-1:0]  pos;
  logic [CNT_W-1:0]  n1;
  logic              last;
  logic [CNT_W-1:0]  n1_sat;
  logic [TERM_W-1:0] term;
  logic [POS_W-1:0]  current_window;
  logic [SUM_W-1:0]  pair_sum;
  logic [SUM_W:0]    sum_ext;
  logic [END_W-1:0]  win_end;
  logic              win_ok;
  logic [POS_W-1:0]  tgt;
  logic [END_W-1:0]  end_cand;
  logic [POS_W-1:0]  pos_m1;
  logic              sat;
  logic [DIV_W-1:0]  pi;

  // Divider
  logic              div_start;
  logic [STEP_W-1:0] div_steps;
  logic [POS_W-1:0]  div_divisor;
  logic [POS_W-1:0]  div_rem_init;
  logic [DIV_W-1:0]  div_q_init;
  logic              div_done;
  logic [DIV_W-1:0]  div_quot;
  logic [POS_W-1:0]  div_rem;

  assign wsize  = (window_size == '0) ? POS_W'(1) : window_size;
  assign pos_m1 = pos - 1'b1;
  assign n1_sat = (n1 > hap_count) ? hap_count : n1;

  // Configuration writes invalidate the cached window end
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RESET;
      hap_count   <= HAP_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_SIZE: window_size <= cfg_data;
        REG_HAP_COUNT:   hap_count   <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pair count and site term, registered products
  always_ff @(posedge clk) begin
    pairs <= POS_W'((TERM_W'(hap_count) * TERM_W'(hap_count - 1'b1)) >> 1);
    term  <= TERM_W'(n1_sat) * TERM_W'(hap_count - n1_sat);
  end

  // Site capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pos  <= in_position;
      n1   <= in_derived_count;
      last <= in_last_site;
    end
  end

  // Divider operands
  assign div_start    = cmd.div_tgt | cmd.div_pi;
  assign div_steps    = cmd.div_pi ? STEPS_PI : STEPS_TGT;
  assign div_divisor  = cmd.div_pi ? pairs : wsize;
  assign div_rem_init = cmd.div_pi ? pair_sum[POS_W+INT_W-1:INT_W] : '0;
  assign div_q_init   = cmd.div_pi ? {pair_sum[INT_W-1:0], FRAC_W'(0)}
                                   : {pos_m1, (DIV_W - POS_W)'(0)};

  wnd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .steps    (div_steps),
    .divisor  (div_divisor),
    .rem_init (div_rem_init),
    .q_init   (div_q_init),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Quotient overflow check taken when the diversity divide starts
  always_ff @(posedge clk) begin
    if (cmd.div_pi) begin
      sat <= (pair_sum >= SUM_W'({pairs, INT_W'(0)}));
    end
  end

  always_comb begin
    if (hap_count < CNT_W'(2)) begin
      pi = '0;
    end else if (sat) begin
      pi = '1;
    end else begin
      pi = div_quot;
    end
  end

  // Target window; its end is q*W + W = (pos-1) - rem + W
  always_ff @(posedge clk) begin
    if (cmd.tgt_cap) begin
      tgt      <= div_quot[POS_W-1:0];
      end_cand <= END_W'(pos_m1 - div_rem) + END_W'(wsize);
    end
  end

  assign sum_ext = {1'b0, pair_sum} + (SUM_W + 1)'(term);

  // Window state
  always_ff @(posedge clk) begin
    if (rst) begin
      current_window <= '0;
      pair_sum       <= '0;
      win_ok         <= 1'b0;
    end else begin
      if (cmd.win_set && (tgt == current_window)) begin
        win_end <= end_cand;
        win_ok  <= 1'b1;
      end
      if (cmd.close) begin
        current_window <= tgt;
        pair_sum       <= '0;
        win_end        <= end_cand;
        win_ok         <= 1'b1;
      end
      if (cmd.add) begin
        pair_sum <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      end
      if (cmd.fin) begin
        current_window <= '0;
        pair_sum       <= '0;
        win_ok         <= 1'b0;
      end
      if (cfg_we) begin
        win_ok <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.close || cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.close || cmd.fin) begin
      out_window_index <= current_window;
      out_diversity    <= pi;
      out_empty_after  <= cmd.close ? POS_W'(tgt - current_window - 1'b1) : '0;
      out_final_window <= cmd.fin;
    end
  end

  // Status
  assign st.fast     = (pos == '0) || (win_ok && (END_W'(pos) <= win_end));
  assign st.div_done = div_done;
  assign st.tgt_gt   = (tgt > current_window);
  assign st.last     = last;
  assign st.out_free = !out_valid || out_ready;

endmodule
